// ----- rtl/brc_pkg.sv -----
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants of the bitmap row to RGB565 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package brc_pkg;

  localparam int unsigned DIM_W       = 11;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned ADDR_W      = 21;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [ADDR_W-1:0] LINE_STRIDE = ADDR_W'(1280);
  localparam logic [DIM_W-1:0]  MAX_WIDTH   = DIM_W'(1280);
  localparam logic [DIM_W-1:0]  MAX_HEIGHT  = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  WIDTH_RST   = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RST  = DIM_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef struct packed {
    logic [4:0]        red5;
    logic [5:0]        green6;
    logic [4:0]        blue5;
    logic [ADDR_W-1:0] addr;
    logic              done;
  } pix_item_t;

endpackage

`default_nettype wire

// ----- rtl/brc_front.sv -----
// ----------------------------------------------------------------------------
// brc_front
// Byte classifier: skips row padding, gathers three bytes per pixel and
// tracks column, row and frame-buffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_front import brc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 byte_accept,
  input  wire logic [BYTE_W-1:0]    pixel_byte,
  output logic                      item_valid,
  output pix_item_t                 item
);

  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [4:0]        low_r, low_nxt;
  logic [5:0]        mid_r, mid_nxt;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              col_last, row_last;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = height_r;
    end
  end

  assign col_last = ({1'b0, col_r} + (DIM_W+1)'(1)) >= {1'b0, w_eff};
  assign row_last = ({2'b00, row_r} + (DIM_W+1)'(1)) >= {1'b0, h_eff};

  always_comb begin
    phase_nxt    = phase_r;
    col_nxt      = col_r;
    pad_nxt      = pad_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    low_nxt      = low_r;
    mid_nxt      = mid_r;
    item_valid   = 1'b0;
    item.red5    = pixel_byte[7:3];
    item.green6  = mid_r;
    item.blue5   = low_r;
    item.addr    = row_base_r + ADDR_W'(col_r);
    item.done    = 1'b0;
    if (byte_accept) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else begin
        case (phase_r)
          PHASE_FIRST: begin
            low_nxt   = pixel_byte[7:3];
            phase_nxt = PHASE_SECOND;
          end
          PHASE_SECOND: begin
            mid_nxt   = pixel_byte[7:2];
            phase_nxt = PHASE_THIRD;
          end
          default: begin
            item_valid = 1'b1;
            phase_nxt  = PHASE_FIRST;
            if (col_last) begin
              col_nxt = '0;
              pad_nxt = w_eff[1:0];
              if (row_last) begin
                item.done    = 1'b1;
                row_nxt      = '0;
                row_base_nxt = '0;
              end else begin
                row_nxt      = row_r + ROW_W'(1);
                row_base_nxt = row_base_r + LINE_STRIDE;
              end
            end else begin
              col_nxt = col_r + DIM_W'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      phase_r    <= PHASE_FIRST;
      col_r      <= '0;
      pad_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
      low_r      <= '0;
      mid_r      <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      phase_r    <= phase_nxt;
      col_r      <= col_nxt;
      pad_r      <= pad_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
      low_r      <= low_nxt;
      mid_r      <= mid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/brc_queue.sv -----
// ----------------------------------------------------------------------------
// brc_queue
// Short pixel queue between the byte classifier and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_queue import brc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  pix_item_t      wr_item,
  output logic           q_full,
  input  wire logic      rd_en,
  output logic           q_empty,
  output pix_item_t      rd_item
);

  pix_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign q_full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign q_empty = count_r == '0;
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/brc_back.sv -----
// ----------------------------------------------------------------------------
// brc_back
// Output stage: packs queued pixels into 5-6-5 form and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_back import brc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  pix_item_t       q_item,
  output logic            q_rd,
  input  wire logic       pop,
  output logic            empty,
  output logic [PIX_W-1:0]  pixel_value,
  output logic [ADDR_W-1:0] pixel_address,
  output logic              image_done
);

  logic              valid_r, valid_nxt;
  logic [PIX_W-1:0]  value_r;
  logic [ADDR_W-1:0] addr_r;
  logic              done_r;

  assign q_rd      = !q_empty && (!valid_r || pop);
  assign valid_nxt = q_rd || (valid_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      value_r <= {q_item.red5, q_item.green6, q_item.blue5};
      addr_r  <= q_item.addr;
      done_r  <= q_item.done;
    end
  end

  assign empty         = !valid_r;
  assign pixel_value   = value_r;
  assign pixel_address = addr_r;
  assign image_done    = done_r;

endmodule

`default_nettype wire

// ----- rtl/bmp_row_to_rgb565_converter.sv -----
// ----------------------------------------------------------------------------
// bmp_row_to_rgb565_converter
// Converts 24-bit bitmap pixel bytes into RGB565 pixels with addresses.
// ----------------------------------------------------------------------------
// Input: one pixel-data byte per item on in_pixel_byte, taken when push is
//   high and full is low. Row padding bytes are consumed without output.
// Output: queue-style; while empty is low the oldest pixel sits on
//   out_pixel_value / out_pixel_address / out_image_done, taken with pop.
// Config: cfg_valid/cfg_ready write port, cfg_ready always high; index 0
//   sets the image width, index 1 the height. Write only while idle.
// Throughput: one byte per cycle unless full, so one pixel per three bytes.
// Path: the third byte of a pixel is written into the queue at the edge
//   that takes it; the output register loads it from the queue once the
//   register is empty or being popped.
// Stall: a four-entry queue plus the output register absorb results; when
//   they fill, full rises and input bytes are held off.
// Reset: counters clear, width 640 and height 480, queue and outputs empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_row_to_rgb565_converter import brc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [BYTE_W-1:0]    in_pixel_byte,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [PIX_W-1:0]          out_pixel_value,
  output logic [ADDR_W-1:0]         out_pixel_address,
  output logic                      out_image_done
);

  logic      byte_accept;
  logic      item_valid;
  pix_item_t front_item;
  logic      q_full, q_empty, q_rd;
  pix_item_t q_item;

  assign cfg_ready   = 1'b1;
  assign full        = q_full;
  assign byte_accept = push && !q_full;

  brc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_accept (byte_accept),
    .pixel_byte  (in_pixel_byte),
    .item_valid  (item_valid),
    .item        (front_item)
  );

  brc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (item_valid),
    .wr_item (front_item),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .q_empty (q_empty),
    .rd_item (q_item)
  );

  brc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_rd          (q_rd),
    .pop           (pop),
    .empty         (empty),
    .pixel_value   (out_pixel_value),
    .pixel_address (out_pixel_address),
    .image_done    (out_image_done)
  );

endmodule

`default_nettype wire

// ----- tb/sv/bmp_row_to_rgb565_converter_tb.sv -----
// ----------------------------------------------------------------------------
// bmp_row_to_rgb565_converter_tb
// Streams bitmap pixel bytes through the converter under random push and
// pop gaps. A pixel tracker follows the row, column, padding and image
// counters. It checks every popped pixel's value, address and end-of-image
// flag in order. Width and height are rewritten between bursts: extremes,
// zero, saturating values and ignored indexes, often in the middle of an
// image.
// ----------------------------------------------------------------------------
module bmp_row_to_rgb565_converter_tb;
  import brc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned SETTLE      = 6;

  class rgb565_pixel_tracker;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [1:0]        byte_pos;
    logic [DIM_W-1:0]  column;
    logic [1:0]        pad_left;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] row_base;
    logic [4:0]        blue_hold;
    logic [5:0]        green_hold;
    pix_item_t         expected_pixels[$];
    int unsigned       errors;
    int unsigned       pixels_checked;
    int unsigned       images_done;
    int unsigned       reg_writes;

    function new();
      width_reg      = WIDTH_RST;
      height_reg     = HEIGHT_RST;
      byte_pos       = PHASE_FIRST;
      column         = '0;
      pad_left       = '0;
      row            = '0;
      row_base       = '0;
      blue_hold      = '0;
      green_hold     = '0;
      errors         = 0;
      pixels_checked = 0;
      images_done    = 0;
      reg_writes     = 0;
    endfunction

    function logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
      if (v == '0) return DIM_W'(1);
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      reg_writes++;
      if (idx == REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
    endfunction

    // returns 1 when the byte is row padding
    function bit take_byte(logic [BYTE_W-1:0] b);
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      pix_item_t px;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (pad_left != 2'd0) begin
        pad_left = pad_left - 2'd1;
        return 1'b1;
      end
      case (byte_pos)
        PHASE_FIRST: begin
          blue_hold = b[7:3];
          byte_pos  = PHASE_SECOND;
        end
        PHASE_SECOND: begin
          green_hold = b[7:2];
          byte_pos   = PHASE_THIRD;
        end
        default: begin
          px.red5   = b[7:3];
          px.green6 = green_hold;
          px.blue5  = blue_hold;
          px.addr   = row_base + ADDR_W'(column);
          px.done   = 1'b0;
          byte_pos  = PHASE_FIRST;
          if (32'(column) + 32'd1 >= 32'(w)) begin
            column   = '0;
            pad_left = w[1:0];
            if (32'(row) + 32'd1 >= 32'(h)) begin
              px.done  = 1'b1;
              row      = '0;
              row_base = '0;
            end else begin
              row      = row + ROW_W'(1);
              row_base = row_base + LINE_STRIDE;
            end
          end else begin
            column = column + DIM_W'(1);
          end
          expected_pixels.push_back(px);
        end
      endcase
      return 1'b0;
    endfunction

    function void check_pixel(logic [PIX_W-1:0] value, logic [ADDR_W-1:0] addr,
                              logic done);
      pix_item_t px;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: value %h address %0d done %b", value, addr, done);
        errors++;
        return;
      end
      px = expected_pixels.pop_front();
      pixels_checked++;
      if (px.done) images_done++;
      if (value !== {px.red5, px.green6, px.blue5}) begin
        $error("pixel_value: expected %h, got %h", {px.red5, px.green6, px.blue5}, value);
        errors++;
      end
      if (addr !== px.addr) begin
        $error("pixel_address: expected %0d, got %0d", px.addr, addr);
        errors++;
      end
      if (done !== px.done) begin
        $error("image_done: expected %b, got %b", px.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 push;
  logic                 full;
  logic [BYTE_W-1:0]    in_pixel_byte;
  logic                 pop;
  logic                 empty;
  logic [PIX_W-1:0]     out_pixel_value;
  logic [ADDR_W-1:0]    out_pixel_address;
  logic                 out_image_done;

  rgb565_pixel_tracker tracker = new();
  bit                  no_idle = 1'b0;
  int unsigned         cycle_count = 0;
  int unsigned         bytes_sent = 0;

  bmp_row_to_rgb565_converter u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_pixel_byte     (in_pixel_byte),
    .pop               (pop),
    .empty             (empty),
    .out_pixel_value   (out_pixel_value),
    .out_pixel_address (out_pixel_address),
    .out_image_done    (out_image_done)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL bmp_row_to_rgb565_converter");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [DIM_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return DIM_W'(2047);
    if (r < 22) return MAX_WIDTH;
    if (r < 26) return DIM_W'($urandom_range(1281, 2046));
    return DIM_W'($urandom_range(1, 9));
  endfunction

  function automatic logic [DIM_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return DIM_W'(2047);
    if (r < 18) return MAX_HEIGHT;
    return DIM_W'($urandom_range(1, 4));
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, output bit was_pad);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push          = 1'b1;
    in_pixel_byte = b;
    do @(posedge clk); while (full);
    was_pad = tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_random(input int unsigned count);
    bit was_pad;
    repeat (count) send_byte(8'($urandom_range(0, 255)), was_pad);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push = 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side: pop with random stalls
  initial begin
    int unsigned stall;
    pop   = 1'b0;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall != 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        tracker.check_pixel(out_pixel_value, out_pixel_address, out_image_done);
        stall = pick_gap();
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] edge_bytes [24];
    int unsigned       r;
    bit                was_pad;

    edge_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                   8'h00, 8'h80, 8'h40, 8'h08, 8'h07, 8'h03, 8'hF8, 8'hFC,
                   8'hF8, 8'h7F, 8'h01, 8'h55, 8'hAA, 8'hC3, 8'h3C, 8'hE7};
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    push          = 1'b0;
    in_pixel_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset dimensions
    send_random(30);
    wait_idle();

    // tall image, one pixel per row with one padding byte
    write_reg(REG_IMAGE_WIDTH, DIM_W'(1));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2047));
    send_random(400);
    wait_idle();

    // wide image, single row
    write_reg(REG_IMAGE_WIDTH, DIM_W'(2047));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(1));
    send_random(240);
    wait_idle();

    // zero dimensions act as one; ignored indexes
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    write_reg(CFG_IDX_W'(2), DIM_W'(2047));
    write_reg(CFG_IDX_W'(3), '0);
    for (int i = 0; i < 8; i++) send_byte(edge_bytes[i], was_pad);
    wait_idle();

    write_reg(REG_IMAGE_WIDTH, DIM_W'(3));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    for (int i = 8; i < 24; i++) send_byte(edge_bytes[i], was_pad);
    wait_idle();

    while (bytes_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) write_reg(REG_IMAGE_WIDTH, pick_width());
      if (r >= 30) write_reg(REG_IMAGE_HEIGHT, pick_height());
      if ($urandom_range(0, 99) < 15)
        write_reg(CFG_IDX_W'($urandom_range(2, 3)), DIM_W'($urandom_range(0, 2047)));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(15, 90)) begin
        send_byte(8'($urandom_range(0, 255)), was_pad);
      end
      wait_idle();
    end

    $display("sent %0d bytes and %0d register writes; checked %0d pixels, %0d images",
             bytes_sent, tracker.reg_writes, tracker.pixels_checked, tracker.images_done);
    if (tracker.errors == 0) begin
      $display("PASS bmp_row_to_rgb565_converter");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("FAIL bmp_row_to_rgb565_converter");
    end
    $finish;
  end

endmodule
